// ----- hw/rtl/hsv_color_dimmer_top_defines.svh -----
// assertion macros used by the port-level checker
// no dependencies
`ifndef HSV_COLOR_DIMMER_TOP_DEFINES_SVH
`define HSV_COLOR_DIMMER_TOP_DEFINES_SVH
// implication checked every edge outside reset
`define HCD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define HCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ----- hw/rtl/hcd_pkg.sv -----
// shared constants and types for the hsv color dimmer
// no dependencies
`default_nettype none
package hcd_pkg;
	localparam int unsigned NumStages = 9;
	localparam logic [1:0] ModeDim = 2'd0;
	localparam logic [1:0] ModeToHsv = 2'd1;
	localparam logic [1:0] ModeToRgb = 2'd2;
	localparam logic [1:0] ModePass = 2'd3;
	localparam logic RegMode = 1'b0;
	localparam logic RegBright = 1'b1;
	typedef logic [23:0] pixel_t;
endpackage
`default_nettype wire

// ----- hw/rtl/hsv_color_dimmer_top.sv -----
// hsv color dimmer top level: rgb/hsv conversion and v scaling
// depends on hcd_pkg and hcd_div
// throughput: one word per cycle; a stalled result word freezes every stage and stalls the input
// the two-stage dividers and the reciprocal multiplies set the stage split
// reset clears valid bits and sets mode 0, brightness 255
`default_nettype none
module hsv_color_dimmer_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire hcd_pkg::pixel_t    pixel_in,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output hcd_pkg::pixel_t         pixel_out
);
	import hcd_pkg::*;
	logic [1:0] mode_q;
	logic [7:0] bright_q;
	logic [NumStages-1:0] vld_q;
	logic adv;
	assign adv = !(vld_q[NumStages-1] && out_stall);
	assign in_stall = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[NumStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ModeDim;
			bright_q <= 8'hff;
			vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == RegMode) mode_q <= cfg_data[1:0];
				else bright_q <= cfg_data;
			end
			if (adv) vld_q <= {vld_q[NumStages-2:0], in_valid};
		end
	end

	// s1: max/min, hue numerator
	pixel_t px_s1;
	logic [7:0] mx_s1, d_s1;
	logic [10:0] n_s1;
	logic [7:0] r, g, b, mx, mn;
	logic [10:0] n;
	always_comb begin
		r = pixel_in[23:16]; g = pixel_in[15:8]; b = pixel_in[7:0];
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		if (r == mx) begin
			n = {3'd0, g} - {3'd0, b};
			if (g < b) n = n + 11'(6 * (mx - mn));
		end else if (g == mx) begin
			n = 11'(2 * (mx - mn)) + {3'd0, b} - {3'd0, r};
		end else begin
			n = 11'(4 * (mx - mn)) + {3'd0, r} - {3'd0, g};
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= pixel_in; mx_s1 <= mx; d_s1 <= mx - mn; n_s1 <= n;
		end
	end

	// s2, s3: h and s divides
	logic [7:0] h_div, s_div;
	logic [10:0] d6;
	assign d6 = 11'(6 * d_s1);
	hcd_div u_hdiv (.clk(clk), .en(adv), .num(19'(255 * n_s1)),
		.den((d_s1 == 0) ? 11'd1 : d6), .quo(h_div));
	hcd_div u_sdiv (.clk(clk), .en(adv), .num(19'(255 * d_s1)),
		.den((mx_s1 == 0) ? 11'd1 : {3'd0, mx_s1}), .quo(s_div));
	pixel_t px_s2, px_s3;
	logic [7:0] mx_s2, mx_s3;
	logic gray_s2, gray_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s2 <= px_s1; mx_s2 <= mx_s1; gray_s2 <= (d_s1 == 0);
			px_s3 <= px_s2; mx_s3 <= mx_s2; gray_s3 <= gray_s2;
		end
	end

	// s4: select hsv source and scale v
	pixel_t px_s4, hsv_s4;
	logic [1:0] md_s4;
	logic [7:0] hh, ss, vv;
	logic [15:0] vb, vsum;
	always_comb begin
		hh = gray_s3 ? 8'd0 : h_div;
		ss = gray_s3 ? 8'd0 : s_div;
		vb = mx_s3 * bright_q;
		// floor divide by 255, exact for products up to 255*255
		vsum = vb + 16'd1 + (vb >> 8);
		vv = vsum[15:8];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s4 <= px_s3; md_s4 <= mode_q;
			hsv_s4 <= (mode_q == ModeDim) ? {hh, ss, vv} : (mode_q == ModeToHsv) ?
				{hh, ss, mx_s3} : px_s3;
		end
	end

	// s5: sector and fraction
	logic [10:0] x, xs;
	logic [2:0] sec;
	logic [7:0] ff;
	logic [2:0] sec_s5;
	logic [7:0] f_s5;
	pixel_t px_s5, hsv_s5;
	logic [1:0] md_s5;
	always_comb begin
		x = (hsv_s4[23:16] == 8'hff) ? 11'd0 : 11'(6 * hsv_s4[23:16]);
		xs = x + 11'd1 + (x >> 8);
		sec = xs[10:8];
		ff = 8'(x - ({sec, 8'd0} - {8'd0, sec}));
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s5 <= sec; f_s5 <= ff;
			px_s5 <= px_s4; hsv_s5 <= hsv_s4; md_s5 <= md_s4;
		end
	end

	// s6: products s*f and s*(255-f)
	logic [15:0] sf_s6, sg_s6;
	logic [2:0] sec_s6;
	pixel_t px_s6, hsv_s6;
	logic [1:0] md_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			sf_s6 <= hsv_s5[15:8] * f_s5;
			sg_s6 <= hsv_s5[15:8] * (8'd255 - f_s5);
			sec_s6 <= sec_s5; px_s6 <= px_s5; hsv_s6 <= hsv_s5; md_s6 <= md_s5;
		end
	end

	// s7: v products
	logic [15:0] pq_s7;
	logic [23:0] qq_s7, tq_s7;
	logic [2:0] sec_s7;
	pixel_t px_s7, hsv_s7;
	logic [1:0] md_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			pq_s7 <= hsv_s6[7:0] * (8'd255 - hsv_s6[15:8]);
			qq_s7 <= {16'd0, hsv_s6[7:0]} * (24'd65025 - {8'd0, sf_s6});
			tq_s7 <= {16'd0, hsv_s6[7:0]} * (24'd65025 - {8'd0, sg_s6});
			sec_s7 <= sec_s6; px_s7 <= px_s6; hsv_s7 <= hsv_s6; md_s7 <= md_s6;
		end
	end

	// s8: constant divides
	logic [15:0] psum;
	logic [47:0] qm, tm;
	logic [7:0] p_s8, q_s8, t_s8;
	logic [2:0] sec_s8;
	pixel_t px_s8, hsv_s8;
	logic [1:0] md_s8;
	always_comb begin
		psum = pq_s7 + 16'd1 + (pq_s7 >> 8);
		// reciprocal of 65025 scaled by 2^40, exact for 24 bit numerators
		qm = {24'd0, qq_s7} * 48'd16909061;
		tm = {24'd0, tq_s7} * 48'd16909061;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8 <= psum[15:8];
			q_s8 <= qm[47:40];
			t_s8 <= tm[47:40];
			sec_s8 <= sec_s7; px_s8 <= px_s7; hsv_s8 <= hsv_s7; md_s8 <= md_s7;
		end
	end

	// s9: sector mux, mode select
	logic [7:0] v8;
	pixel_t rgb;
	assign v8 = hsv_s8[7:0];
	always_comb begin
		case (sec_s8)
			3'd0: rgb = {v8, t_s8, p_s8};
			3'd1: rgb = {q_s8, v8, p_s8};
			3'd2: rgb = {p_s8, v8, t_s8};
			3'd3: rgb = {p_s8, q_s8, v8};
			3'd4: rgb = {t_s8, p_s8, v8};
			default: rgb = {v8, p_s8, q_s8};
		endcase
		if (hsv_s8[15:8] == 8'd0) rgb = {v8, v8, v8};
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			case (md_s8)
				ModeDim, ModeToRgb: pixel_out <= rgb;
				ModeToHsv: pixel_out <= hsv_s8;
				default: pixel_out <= px_s8;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/hcd_div.sv -----
// two-stage pipelined restoring divider: 19 bit dividend by 11 bit divisor, 8 bit quotient
// assumes quotient fits in 8 bits; no dependencies
`default_nettype none
module hcd_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [18:0] num,
	input  wire logic [10:0] den,
	output logic      [7:0]  quo
);
	// upper four quotient bits in the first stage, lower four in the second
	logic [18:0] rem_a, rem_b, rem_s1;
	logic [3:0]  qa, qb, qhi_s1;
	logic [10:0] den_s1;
	logic [19:0] trial_a, trial_b;
	always_comb begin
		rem_a = num;
		qa = '0;
		trial_a = '0;
		for (int k = 3; k >= 0; k--) begin
			trial_a = {1'b0, rem_a} - ({9'd0, den} << (k + 4));
			if (!trial_a[19]) begin
				rem_a = trial_a[18:0];
				qa[k] = 1'b1;
			end
		end
	end
	always_comb begin
		rem_b = rem_s1;
		qb = '0;
		trial_b = '0;
		for (int k = 3; k >= 0; k--) begin
			trial_b = {1'b0, rem_b} - ({9'd0, den_s1} << k);
			if (!trial_b[19]) begin
				rem_b = trial_b[18:0];
				qb[k] = 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= rem_a;
			qhi_s1 <= qa;
			den_s1 <= den;
			quo <= {qhi_s1, qb};
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/hcd_checker.sv -----
// port-level checker for the hsv color dimmer, bound to the top level
// depends on hsv_color_dimmer_top_defines.svh
`default_nettype none
`include "hsv_color_dimmer_top_defines.svh"
module hcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [23:0] pixel_out
);
	// a stalled result word holds
	`HCD_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(pixel_out))
	// input only stalls when output is full and stalled
	`HCD_ASSERT_IMP(a_stall, in_stall, out_valid && out_stall)
	// no stall means the input side is free
	`HCD_ASSERT_IMP(a_free, !out_stall, !in_stall)
endmodule
bind hsv_color_dimmer_top hcd_checker u_chk (.*);
`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for hsv_color_dimmer_top: predicts every result pixel
// depends on hcd_pkg and the hsv_color_dimmer_top rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import hcd_pkg::*;

	class pixel_scoreboard;
		logic [1:0] mode;
		logic [7:0] bright;
		pixel_t expected_q[$];
		int unsigned mismatches;

		function new();
			mode = ModeDim;
			bright = 8'd255;
			mismatches = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] data);
			if (idx == RegMode) begin
				mode = data[1:0];
			end else begin
				bright = data;
			end
		endfunction

		function pixel_t rgb_to_hsv(pixel_t px);
			int unsigned r, g, b, mx, mn, d, s, h, n;
			r = 32'(px[23:16]);
			g = 32'(px[15:8]);
			b = 32'(px[7:0]);
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			// gray: hue and saturation both zero
			if (d == 0) return pixel_t'(mx);
			s = (255 * d) / mx;
			if (r >= mx) begin
				n = (g >= b) ? g - b : 6 * d + g - b;
			end else if (g >= mx) begin
				n = 2 * d + b - r;
			end else begin
				n = 4 * d + r - g;
			end
			h = (255 * n) / (6 * d);
			return {h[7:0], s[7:0], mx[7:0]};
		endfunction

		function pixel_t hsv_to_rgb(pixel_t px);
			int unsigned h, s, v, x, f, p, q, t;
			h = 32'(px[23:16]);
			s = 32'(px[15:8]);
			v = 32'(px[7:0]);
			if (s == 0) return {v[7:0], v[7:0], v[7:0]};
			// full circle wraps to sector zero
			x = (h == 255) ? 0 : 6 * h;
			f = x % 255;
			p = (v * (255 - s)) / 255;
			q = (v * (65025 - s * f)) / 65025;
			t = (v * (65025 - s * (255 - f))) / 65025;
			case (x / 255)
				0: return {v[7:0], t[7:0], p[7:0]};
				1: return {q[7:0], v[7:0], p[7:0]};
				2: return {p[7:0], v[7:0], t[7:0]};
				3: return {p[7:0], q[7:0], v[7:0]};
				4: return {t[7:0], p[7:0], v[7:0]};
				default: return {v[7:0], p[7:0], q[7:0]};
			endcase
		endfunction

		function pixel_t dimmed(pixel_t px);
			pixel_t hsv;
			int unsigned v;
			hsv = rgb_to_hsv(px);
			v = (32'(hsv[7:0]) * 32'(bright)) / 255;
			return hsv_to_rgb({hsv[23:8], v[7:0]});
		endfunction

		function void note_input(pixel_t px);
			case (mode)
				ModeDim: expected_q.push_back(dimmed(px));
				ModeToHsv: expected_q.push_back(rgb_to_hsv(px));
				ModeToRgb: expected_q.push_back(hsv_to_rgb(px));
				default: expected_q.push_back(px);
			endcase
		endfunction

		function void check_result(pixel_t actual);
			pixel_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %06h", actual);
				return;
			end
			want = expected_q.pop_front();
			if (want !== actual) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pixel mismatch: expected %06h actual %06h", want, actual);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	pixel_t pixel_in;
	logic out_valid;
	logic out_stall;
	pixel_t pixel_out;
	bit calm;
	pixel_scoreboard sb;

	hsv_color_dimmer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_in(pixel_in),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall = !calm && ($urandom_range(0, 99) < 31);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(pixel_out);
	end

	task automatic write_reg(logic idx, logic [7:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_word(pixel_t px);
		while (!calm && $urandom_range(0, 99) < 31) begin
			in_valid = 1'b0;
			pixel_in = pixel_t'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		pixel_in = px;
		do @(posedge clk); while (in_stall);
		sb.note_input(px);
		@(negedge clk);
	endtask

	// holds off the sender until the pipeline has drained
	task automatic drain();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (NumStages + 4) @(negedge clk);
	endtask

	task automatic set_regs(logic [1:0] m, logic [7:0] br);
		drain();
		// upper data bits of the mode write must be ignored
		write_reg(RegMode, {6'($urandom), m});
		write_reg(RegBright, br);
	endtask

	function automatic pixel_t random_pixel();
		logic [7:0] a, b, c;
		a = 8'($urandom);
		b = 8'($urandom);
		c = 8'($urandom);
		case ($urandom_range(0, 9))
			0: return {a, a, a};
			1: return {a, a, b};
			2: return {a, b, a};
			3: return {b, a, a};
			4: return {8'hff, a, 8'h00};
			5: return {a, 8'h00, c};
			6: return {8'hff, b, c};
			default: return {a, b, c};
		endcase
	endfunction

	pixel_t directed_rgb[] = '{24'h000000, 24'h808080, 24'hffffff, 24'hff0000,
		24'hffff00, 24'h00ffff, 24'hff00ff, 24'h123456, 24'h00ff00, 24'h0000ff};
	pixel_t directed_hsv[] = '{24'hff80ff, 24'h7a00c8, 24'h2affff, 24'hffffff,
		24'h000000, 24'h55ff80, 24'haa40ff, 24'hd4ff01};
	logic [1:0] modes[7] = '{ModeDim, ModeDim, ModeToHsv, ModeToRgb, ModeDim,
		ModePass, ModeDim};
	logic [7:0] brights[7] = '{8'd255, 8'd0, 8'd17, 8'd1, 8'd128, 8'd200, 8'd254};

	initial begin
		int unsigned lim;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = RegMode;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		out_stall = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset values: dim with full brightness
		foreach (directed_rgb[i]) send_word(directed_rgb[i]);
		set_regs(ModeToHsv, 8'd255);
		foreach (directed_rgb[i]) send_word(directed_rgb[i]);
		set_regs(ModeToRgb, 8'd0);
		foreach (directed_hsv[i]) send_word(directed_hsv[i]);
		set_regs(ModePass, 8'd0);
		send_word(24'habcdef);
		set_regs(ModeDim, 8'd0);
		send_word(24'hff8040);

		for (int ph = 0; ph < 7; ph++) begin
			set_regs(modes[ph], brights[ph]);
			calm = (ph == 4);
			for (int k = 0; k < 150; k++) send_word(random_pixel());
		end
		calm = 1'b0;
		in_valid = 1'b0;

		lim = 0;
		while (sb.expected_q.size() != 0 && lim < 20000) begin
			@(posedge clk);
			lim++;
		end
		repeat (NumStages + 10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
